[hdl/sols_pkg.sv]
// Package: shared constants, types and control structs for the list search block.
`default_nettype none
package sols_pkg;

    localparam int LIST_LEN = 128;
    localparam int KEY_W    = 8;
    localparam int IDX_W    = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
    localparam int MODE_W   = 2;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_NONE      = 2'd0;
    localparam t_mode MODE_MTF       = 2'd1;
    localparam t_mode MODE_TRANSPOSE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ENCODE,
        ST_UPDATE
    } t_state;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic  en;    // reorder this cycle (key found, not at the front)
        t_mode mode;
        t_idx  pos;   // 0-based position of the hit
        t_key  key;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[hdl/sols_if.sv]
// Interfaces: search request, search result and mode write channels.
`default_nettype none
interface sols_key_if;
    import sols_pkg::*;
    logic valid;
    logic ready;
    t_key search_key;
    modport source (output valid, output search_key, input ready);
    modport sink   (input valid, input search_key, output ready);
endinterface

interface sols_res_if;
    import sols_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] visit_count;
    logic       key_found;
    modport source (output valid, output visit_count, output key_found, input ready);
    modport sink   (input valid, input visit_count, input key_found, output ready);
endinterface

interface sols_cfg_if;
    import sols_pkg::*;
    logic  valid;
    logic  ready;
    t_mode reorder_mode;
    modport source (output valid, output reorder_mode, input ready);
    modport sink   (input valid, input reorder_mode, output ready);
endinterface
`default_nettype wire

[hdl/self_organizing_list_search.sv]
// Top level: self-organizing list search with move-to-front and transpose reordering.
`default_nettype none
// The block holds a list of LIST_LEN distinct keys, 1..LIST_LEN after reset,
// one per cell of a row of cells. A search request carries a key; the result
// gives the key's 1-based position before reordering (visit_count) and
// key_found, or 0 and 0 for an absent key. On a hit the row then reorders
// as reorder_mode selects: 0 none, 1 move to front, 2 swap with predecessor,
// 3 acts as 0. A request passes through the states accept, parallel compare in all
// cells, hit encode, and update, in which the cells that the mode selects take the key
// or their left neighbor while the result enters the output register. The
// update waits while the output register still holds an untaken result.
// Mode writes are always ready and belong between searches.
module self_organizing_list_search (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sols_key_if.sink   i_req,
    sols_res_if.source o_res,
    sols_cfg_if.sink   i_cfg
);
    import sols_pkg::*;

    t_state r_state;
    t_state n_state;

    t_mode  r_mode;
    t_key   r_key;
    logic [LIST_LEN-1:0] r_hit;
    logic [LIST_LEN-1:0] hit;
    t_idx   r_pos;
    logic   r_found;
    t_idx   enc_pos;
    logic   enc_found;

    logic       r_out_valid;
    logic [7:0] r_out_count;
    logic       r_out_found;

    logic req_ready;
    logic can_push;
    logic do_update;

    t_cell_ctrl cell_ctrl;
    t_key       entries [LIST_LEN];

    // mode register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.reorder_mode;
        end
    end

    assign can_push = !r_out_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_req.valid) n_state = ST_MATCH;
            ST_MATCH:  n_state = ST_ENCODE;
            ST_ENCODE: n_state = ST_UPDATE;
            ST_UPDATE: if (can_push) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        req_ready = 1'b0;
        do_update = 1'b0;
        unique case (r_state)
            ST_IDLE:   req_ready = 1'b1;
            ST_UPDATE: do_update = can_push;
            default: begin
                req_ready = 1'b0;
                do_update = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_req.ready = req_ready;

    // request payload and pipeline registers
    always_ff @(posedge i_clk) begin
        if (req_ready && i_req.valid) begin
            r_key <= i_req.search_key;
        end
        if (r_state == ST_MATCH) begin
            r_hit <= hit;
        end
        if (r_state == ST_ENCODE) begin
            r_pos   <= enc_pos;
            r_found <= enc_found;
        end
    end

    // reorder only on a hit that is not already at the front
    assign cell_ctrl.en   = do_update && r_found && (r_pos != '0);
    assign cell_ctrl.mode = r_mode;
    assign cell_ctrl.pos  = r_pos;
    assign cell_ctrl.key  = r_key;

    for (genvar g = 0; g < LIST_LEN; g++) begin : g_cell
        sols_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_ctrl  (cell_ctrl),
            .i_left  ((g == 0) ? t_key'(0) : entries[(g == 0) ? 0 : g - 1]),
            .o_entry (entries[g]),
            .o_hit   (hit[g])
        );
    end

    sols_encoder u_encoder (
        .i_hit   (r_hit),
        .o_pos   (enc_pos),
        .o_found (enc_found)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_update) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_out_count <= r_found ? (8'(r_pos) + 8'd1) : 8'd0;
            r_out_found <= r_found;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.visit_count = r_out_count;
    assign o_res.key_found   = r_out_found;

endmodule
`default_nettype wire

[hdl/sols_cell.sv]
// List cell: holds one entry, compares it with the key, takes key or left neighbor on reorder.
`default_nettype none
module sols_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sols_pkg::t_idx     i_index,
    input  wire sols_pkg::t_cell_ctrl i_ctrl,
    input  wire sols_pkg::t_key     i_left,
    output      sols_pkg::t_key     o_entry,
    output      logic               o_hit
);
    import sols_pkg::*;

    t_key r_entry;
    t_key n_entry;
    logic load_key;
    logic shift;

    always_comb begin
        load_key = 1'b0;
        shift    = 1'b0;
        if (i_ctrl.en) begin
            unique case (i_ctrl.mode)
                MODE_MTF: begin
                    load_key = (i_index == '0);
                    shift    = (i_index != '0) && (i_index <= i_ctrl.pos);
                end
                MODE_TRANSPOSE: begin
                    load_key = (i_index == IDX_W'(i_ctrl.pos - 1'b1));
                    shift    = (i_index == i_ctrl.pos);
                end
                default: begin
                    load_key = 1'b0;
                    shift    = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_entry = r_entry;
        if (load_key) begin
            n_entry = i_ctrl.key;
        end else if (shift) begin
            n_entry = i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= KEY_W'(i_index) + KEY_W'(1);
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = (r_entry == i_ctrl.key);

endmodule
`default_nettype wire

[hdl/sols_encoder.sv]
// Hit encoder: one-hot hit vector of the row to position and found flag.
`default_nettype none
module sols_encoder (
    input  wire logic [sols_pkg::LIST_LEN-1:0] i_hit,
    output      sols_pkg::t_idx                o_pos,
    output      logic                          o_found
);
    import sols_pkg::*;

    // Entries are distinct, so at most one hit bit is set: OR of indices.
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < LIST_LEN; i++) begin
            o_pos = o_pos | (i_hit[i] ? IDX_W'(i) : '0);
        end
    end

    assign o_found = |i_hit;

endmodule
`default_nettype wire
